// File: hw/rtl/tdoa_pkg.sv
// Package with the shared types, constants and the reset anchor layout.
package tdoa_pkg;

    localparam int AnchorCount = 8;
    localparam int IdxW = 3;
    localparam int CoordW = 16;
    localparam int SqW = 34;
    localparam int DistW = 18;
    localparam int RootSteps = 17;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_pos;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_MEASURE = 1'b1
    } t_kind;

    function automatic t_pos reset_pos(input logic [IdxW-1:0] idx);
        t_pos p;
        p.x = idx[1] ? 16'sd896 : -16'sd896;
        p.y = (idx[0] ^ idx[1]) ? 16'sd1152 : -16'sd1152;
        p.z = (idx[0] ^ idx[2]) ? 16'sd768 : 16'sd51;
        return p;
    endfunction

endpackage

// File: hw/rtl/tdoa_sqrt.sv
// Pipelined floor square root, up to two result bits resolved per register stage.
module tdoa_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [tdoa_pkg::SqW-1:0]  i_rad,
    input  logic [5:0]                i_tag,
    output logic                      o_valid,
    output logic [tdoa_pkg::RootSteps-1:0] o_root,
    output logic [5:0]                o_tag
);
    import tdoa_pkg::*;

    localparam int Stages = (RootSteps + 1) / 2;
    localparam int RemW = RootSteps + 2;

    logic [SqW-1:0]       r_rad  [1:Stages];
    logic [RemW-1:0]      r_rem  [1:Stages];
    logic [RootSteps-1:0] r_root [1:Stages];
    logic [5:0]           r_tag  [1:Stages];
    logic [Stages:1]      r_vld;

    for (genvar s = 0; s < Stages; s++) begin : g_st
        logic [SqW-1:0]       c_rad;
        logic [RemW-1:0]      c_rem;
        logic [RootSteps-1:0] c_root;
        logic [5:0]           c_tag;
        logic                 c_vld;
        logic [SqW-1:0]       n_rad;
        logic [RemW-1:0]      n_rem;
        logic [RootSteps-1:0] n_root;

        if (s == 0) begin : g_first
            assign c_rad  = i_rad;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_tag  = i_tag;
            assign c_vld  = i_valid;
        end else begin : g_next
            assign c_rad  = r_rad[s];
            assign c_rem  = r_rem[s];
            assign c_root = r_root[s];
            assign c_tag  = r_tag[s];
            assign c_vld  = r_vld[s];
        end

        always_comb begin
            logic [RemW-1:0] trial;
            n_rad  = c_rad;
            n_rem  = c_rem;
            n_root = c_root;
            trial  = '0;
            for (int k = 0; k < 2; k++) begin
                if (s * 2 + k < RootSteps) begin
                    n_rem = {n_rem[RemW-3:0], n_rad[SqW-1 -: 2]};
                    n_rad = {n_rad[SqW-3:0], 2'b00};
                    trial = {n_root, 2'b01};
                    if (n_rem >= trial) begin
                        n_rem  = n_rem - trial;
                        n_root = {n_root[RootSteps-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[RootSteps-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= c_vld;
            end
            if (i_en) begin
                r_rad[s+1]  <= n_rad;
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_tag[s+1]  <= c_tag;
            end
        end
    end

    assign o_valid = r_vld[Stages];
    assign o_root  = r_root[Stages];
    assign o_tag   = r_tag[Stages];
endmodule

// File: hw/rtl/tdoa_distance_difference.sv
// Top level of the range-difference unit: anchor table, squaring stages, roots and output.
// Takes one word per cycle while the output is not stalled. A measure word gives a result
// through these stages: three stages form the differences, squares and sums, the square root
// resolves up to two bits per stage over nine stages, and one output register follows.
// Load words write the anchor table at once and give no result. The table resets to the
// eight-anchor example layout. Output stalls freeze the whole pipeline.
module tdoa_distance_difference (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: first_anchor[2:0], second_anchor[5:3], pos_x[21:6], pos_y[37:22],
    // pos_z[53:38], zero fill [55:54]
    input  logic [55:0] s_axis_tdata,
    // tuser: kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: distance_difference[17:0], anchor_a_echo[20:18], anchor_b_echo[23:21]
    output logic [23:0] m_axis_tdata
);
    import tdoa_pkg::*;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [IdxW-1:0] in_a, in_b;
    t_pos in_p;
    logic in_acc, in_meas;
    assign in_a   = s_axis_tdata[2:0];
    assign in_b   = s_axis_tdata[5:3];
    assign in_p.x = s_axis_tdata[21:6];
    assign in_p.y = s_axis_tdata[37:22];
    assign in_p.z = s_axis_tdata[53:38];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_meas = in_acc && (t_kind'(s_axis_tuser) == KIND_MEASURE);

    t_pos r_tab [AnchorCount];
    logic [AnchorCount-1:0] r_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
        end else if (in_acc && t_kind'(s_axis_tuser) == KIND_LOAD) begin
            r_wr[in_a] <= 1'b1;
        end
        if (in_acc && t_kind'(s_axis_tuser) == KIND_LOAD) begin
            r_tab[in_a] <= in_p;
        end
    end

    t_pos anc_a, anc_b;
    assign anc_a = r_wr[in_a] ? r_tab[in_a] : reset_pos(in_a);
    assign anc_b = r_wr[in_b] ? r_tab[in_b] : reset_pos(in_b);

    // Stage 1: coordinate differences.
    logic r1_v;
    logic signed [16:0] r1_d [6];
    logic [5:0] r1_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= in_meas;
        end
        if (en) begin
            r1_d[0] <= 17'(in_p.x) - 17'(anc_a.x);
            r1_d[1] <= 17'(in_p.y) - 17'(anc_a.y);
            r1_d[2] <= 17'(in_p.z) - 17'(anc_a.z);
            r1_d[3] <= 17'(in_p.x) - 17'(anc_b.x);
            r1_d[4] <= 17'(in_p.y) - 17'(anc_b.y);
            r1_d[5] <= 17'(in_p.z) - 17'(anc_b.z);
            r1_tag  <= {in_b, in_a};
        end
    end

    // Stage 2: squares.
    logic r2_v;
    logic [33:0] r2_sq [6];
    logic [5:0] r2_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r2_sq[i] <= 34'(r1_d[i] * r1_d[i]);
            end
            r2_tag <= r1_tag;
        end
    end

    // Stage 3: sums of squares.
    logic r3_v;
    logic [SqW-1:0] r3_sa, r3_sb;
    logic [5:0] r3_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_sa  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_sb  <= r2_sq[3] + r2_sq[4] + r2_sq[5];
            r3_tag <= r2_tag;
        end
    end

    logic va, vb;
    logic [RootSteps-1:0] ra, rb;
    logic [5:0] tag_a, tag_b;

    tdoa_sqrt u_sqrt_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r3_v), .i_rad(r3_sa), .i_tag(r3_tag),
        .o_valid(va), .o_root(ra), .o_tag(tag_a)
    );
    tdoa_sqrt u_sqrt_b (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r3_v), .i_rad(r3_sb), .i_tag(6'd0),
        .o_valid(vb), .o_root(rb), .o_tag(tag_b)
    );

    logic r_ov;
    logic [23:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= va;
        end
        if (en) begin
            r_od <= {tag_a[5:3], tag_a[2:0], DistW'({1'b0, rb}) - DistW'({1'b0, ra})};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

`ifndef ASSERT_OFF
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        va == vb) else $error("square root lanes out of step");
    a_same_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[20:18] == m_axis_tdata[23:21]
        |-> m_axis_tdata[17:0] == '0) else $error("equal anchors give nonzero result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(r3_sa) && $stable(r3_v))
        else $error("pipeline moved during stall");
    a_tag_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vb |-> tag_b == '0) else $error("second lane tag corrupted");
`endif
endmodule
